// File: hdl/pbsso_pkg.sv
package pbsso_pkg;

  localparam int PHASE_BITS_DEF  = 32;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int PITCH_W   = 19;
  localparam int SR_W      = 18;
  localparam int OCT_W     = 2;
  localparam int LVL_W     = 17;
  localparam int GAIN_W    = LVL_W + 1;
  localparam int CFG_W     = 18;
  localparam int CFG_IDX_W = 2;
  localparam int Q16_SHIFT = 16;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OCTAVE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BYP_TARGET  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BYP_SMOOTH  = 2'd3;

  localparam logic [SR_W-1:0]  SR_RESET  = 18'd44100;
  localparam logic [OCT_W-1:0] OCT_RESET = 2'd1;
  localparam logic [LVL_W-1:0] Q16_ONE   = 17'd65536;

endpackage

// File: hdl/polyblep_sub_square_oscillator_top.sv
// Sub-octave square oscillator with PolyBLEP edge smoothing and a smoothed
// bypass fade.
// Input channel: in_valid / in_stall carry one pitch (1/16 Hz) per beat;
// each beat is one audio sample tick. Output channel: out_valid / out_stall
// carry one signed sample (SAMPLE_BITS wide, saturated) per input beat.
// Configuration: cfg_we writes cfg_wdata into the register at cfg_idx
// (sample rate, octave shift, bypass target, bypass smoothing); write only
// while no sample is in flight.
// Timing: one item at a time. The phase step comes out of a bit-serial
// restoring divider, one numerator bit per cycle; both edge ratios then
// run on two bit-serial dividers side by side, followed by the squaring,
// mix and output steps.
// The result sits in an output register: a new pitch is taken while it waits,
// and a finished sample holds in the last step until that register frees up.
// Reset: phase and bypass level clear, registers return to 44100 Hz, one
// octave down, target 0, smoothing 1.0; the output channel goes empty.
module polyblep_sub_square_oscillator_top #(
  parameter int PHASE_BITS  = pbsso_pkg::PHASE_BITS_DEF,
  parameter int SAMPLE_BITS = pbsso_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [pbsso_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [pbsso_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [pbsso_pkg::PITCH_W-1:0]      in_pitch_freq,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [SAMPLE_BITS-1:0]      out_sample_out
);
  import pbsso_pkg::*;

  localparam int F      = SAMPLE_BITS - 1;
  localparam int NW     = PITCH_W + PHASE_BITS - 5;
  localparam int CNT_W  = $clog2(NW + 1);
  localparam int SH_ONE = PHASE_BITS - 5;
  localparam int SH_TWO = PHASE_BITS - 6;
  localparam int OW     = SAMPLE_BITS + 2;
  localparam int PW2    = OW + GAIN_W;
  localparam int BW     = 2 * GAIN_W;

  localparam logic [PHASE_BITS:0]      ONE_P1 = {1'b1, {PHASE_BITS{1'b0}}};
  localparam logic [F:0]               D_ONE  = {1'b1, {F{1'b0}}};
  localparam logic signed [OW-1:0]     S_POS  = {2'b00, 1'b1, {F{1'b0}}};
  localparam logic signed [PW2-1:0]    LIM    = {{(PW2-F){1'b0}}, {F{1'b1}}};
  localparam logic signed [PW2-1:0]    NLIM   = -LIM;
  localparam logic signed [PW2-1:0]    RND    = {{(PW2-Q16_SHIFT){1'b0}}, 1'b1,
                                                 {(Q16_SHIFT-1){1'b0}}};
  localparam logic signed [BW-1:0]     BRND   = {{(BW-Q16_SHIFT){1'b0}}, 1'b1,
                                                 {(Q16_SHIFT-1){1'b0}}};

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_SETUP = 3'd2;
  localparam logic [2:0] S_EDGE  = 3'd3;
  localparam logic [2:0] S_SQ    = 3'd4;
  localparam logic [2:0] S_MIX   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  // configuration
  logic [SR_W-1:0]  sr_r;
  logic [OCT_W-1:0] oct_r;
  logic [LVL_W-1:0] tgt_r, sm_r;

  // control and state
  logic [2:0]             state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [PHASE_BITS-1:0]  phase_r, phase_nxt;
  logic [LVL_W-1:0]       level_r, level_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // phase-step divider
  logic [NW-1:0]          nsh_r, nsh_nxt;
  logic [SR_W-1:0]        drem_r, drem_nxt;
  logic [PHASE_BITS-1:0]  quo_r, quo_nxt;
  logic                   ovf_r, ovf_nxt;

  // edge lanes: lane 0 at phase, lane 1 at phase plus half a cycle
  logic [PHASE_BITS-1:0]  erem_r [2];
  logic [PHASE_BITS-1:0]  erem_nxt [2];
  logic [F-1:0]           rq_r [2];
  logic [F-1:0]           rq_nxt [2];
  logic                   rise_r [2];
  logic                   rise_nxt [2];
  logic                   fall_r [2];
  logic                   fall_nxt [2];
  logic [F:0]             sq_r [2];
  logic [F:0]             sq_nxt [2];

  logic                   half_r, half_nxt;
  logic signed [BW-1:0]   byp_r, byp_nxt;
  logic signed [PW2-1:0]  mix_r, mix_nxt;
  logic signed [SAMPLE_BITS-1:0] out_r, out_nxt;

  // combinational helpers
  logic                   in_acc;
  logic [SR_W-1:0]        sr_eff;
  logic [SR_W:0]          dtrial, dsub;
  logic                   dge;
  logic [LVL_W-1:0]       tgt_c, sm_c;
  logic signed [GAIN_W-1:0] diff, smv, gain;
  logic signed [BW-1:0]   byp_prod, byp_step;
  logic [PHASE_BITS-1:0]  dt_sat;
  logic [PHASE_BITS-1:0]  tl [2];
  logic [PHASE_BITS:0]    tsum [2];
  logic                   rise_set [2];
  logic                   fall_set [2];
  logic [PHASE_BITS-1:0]  num_set [2];
  logic [PHASE_BITS:0]    etrial [2];
  logic [PHASE_BITS:0]    esub [2];
  logic                   ege [2];
  logic [F:0]             dd_in [2];
  logic [2*F+1:0]         dd [2];
  logic signed [OW-1:0]   term [2];
  logic signed [OW-1:0]   osc;
  logic signed [PW2-1:0]  mix_prod, rnd, sat;

  assign in_stall       = (state_r != S_IDLE);
  assign in_acc         = in_valid && !in_stall;
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_r;

  // phase-step divider datapath
  assign sr_eff = (sr_r == '0) ? SR_W'(1) : sr_r;
  assign dtrial = {drem_r, nsh_r[NW-1]};
  assign dsub   = dtrial - {1'b0, sr_eff};
  assign dge    = (dtrial >= {1'b0, sr_eff});
  assign dt_sat = ovf_r ? {PHASE_BITS{1'b1}} : quo_r;

  // bypass smoothing
  assign tgt_c    = (tgt_r > Q16_ONE) ? Q16_ONE : tgt_r;
  assign sm_c     = (sm_r > Q16_ONE) ? Q16_ONE : sm_r;
  assign diff     = $signed({1'b0, tgt_c}) - $signed({1'b0, level_r});
  assign smv      = $signed({1'b0, sm_c});
  assign byp_prod = diff * smv;
  assign byp_step = (byp_r + BRND) >>> Q16_SHIFT;

  // mix and output scaling
  assign gain     = $signed({1'b0, Q16_ONE - level_r});
  assign osc      = (half_r ? -S_POS : S_POS) + term[0] - term[1];
  assign mix_prod = osc * gain;
  assign rnd      = (mix_r + RND) >>> Q16_SHIFT;
  assign sat      = (rnd > LIM) ? LIM : ((rnd < NLIM) ? NLIM : rnd);

  always_comb begin
    tl[0] = phase_r;
    tl[1] = {~phase_r[PHASE_BITS-1], phase_r[PHASE_BITS-2:0]};
    for (int i = 0; i < 2; i++) begin
      tsum[i]     = {1'b0, tl[i]} + {1'b0, dt_sat};
      rise_set[i] = (tl[i] < dt_sat);
      fall_set[i] = !rise_set[i] && (tsum[i] > ONE_P1);
      if (rise_set[i]) begin
        num_set[i] = tl[i];
      end else if (fall_set[i]) begin
        num_set[i] = PHASE_BITS'(ONE_P1 - {1'b0, tl[i]});
      end else begin
        num_set[i] = '0;
      end
      etrial[i] = {erem_r[i], 1'b0};
      esub[i]   = etrial[i] - {1'b0, quo_r};
      ege[i]    = (etrial[i] >= {1'b0, quo_r});
      dd_in[i]  = D_ONE - {1'b0, rq_r[i]};
      dd[i]     = dd_in[i] * dd_in[i];
      if (rise_r[i]) begin
        term[i] = -$signed({2'b00, sq_r[i]});
      end else if (fall_r[i]) begin
        term[i] = $signed({2'b00, sq_r[i]});
      end else begin
        term[i] = '0;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    phase_nxt     = phase_r;
    level_nxt     = level_r;
    nsh_nxt       = nsh_r;
    drem_nxt      = drem_r;
    quo_nxt       = quo_r;
    ovf_nxt       = ovf_r;
    half_nxt      = half_r;
    byp_nxt       = byp_r;
    mix_nxt       = mix_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    for (int i = 0; i < 2; i++) begin
      erem_nxt[i] = erem_r[i];
      rq_nxt[i]   = rq_r[i];
      rise_nxt[i] = rise_r[i];
      fall_nxt[i] = fall_r[i];
      sq_nxt[i]   = sq_r[i];
    end
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          nsh_nxt   = oct_r[1] ? (NW'(in_pitch_freq) << SH_TWO)
                               : (NW'(in_pitch_freq) << SH_ONE);
          drem_nxt  = '0;
          quo_nxt   = '0;
          ovf_nxt   = 1'b0;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // one numerator bit per cycle; set quotient bits shifted past the top mean saturation
        nsh_nxt  = nsh_r << 1;
        drem_nxt = dge ? dsub[SR_W-1:0] : dtrial[SR_W-1:0];
        quo_nxt  = {quo_r[PHASE_BITS-2:0], dge};
        ovf_nxt  = ovf_r | quo_r[PHASE_BITS-1];
        byp_nxt  = byp_prod;
        if (cnt_r == CNT_W'(NW - 1)) begin
          state_nxt = S_SETUP;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_SETUP: begin
        quo_nxt   = dt_sat;
        half_nxt  = phase_r[PHASE_BITS-1];
        level_nxt = level_r + byp_step[LVL_W-1:0];
        cnt_nxt   = '0;
        for (int i = 0; i < 2; i++) begin
          erem_nxt[i] = num_set[i];
          rise_nxt[i] = rise_set[i];
          fall_nxt[i] = fall_set[i];
        end
        state_nxt = S_EDGE;
      end
      S_EDGE: begin
        for (int i = 0; i < 2; i++) begin
          erem_nxt[i] = ege[i] ? esub[i][PHASE_BITS-1:0] : etrial[i][PHASE_BITS-1:0];
          rq_nxt[i]   = {rq_r[i][F-2:0], ege[i]};
        end
        if (cnt_r == CNT_W'(F - 1)) begin
          state_nxt = S_SQ;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_SQ: begin
        for (int i = 0; i < 2; i++) begin
          sq_nxt[i] = dd[i][2*F:F];
        end
        phase_nxt = phase_r + quo_r;
        state_nxt = S_MIX;
      end
      S_MIX: begin
        mix_nxt   = mix_prod;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free or drains this cycle
        if (!out_valid_r || !out_stall) begin
          out_nxt       = sat[SAMPLE_BITS-1:0];
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sr_r        <= SR_RESET;
      oct_r       <= OCT_RESET;
      tgt_r       <= '0;
      sm_r        <= Q16_ONE;
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      phase_r     <= '0;
      level_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_SAMPLE_RATE: sr_r  <= cfg_wdata[SR_W-1:0];
          REG_OCTAVE:      oct_r <= cfg_wdata[OCT_W-1:0];
          REG_BYP_TARGET:  tgt_r <= cfg_wdata[LVL_W-1:0];
          REG_BYP_SMOOTH:  sm_r  <= cfg_wdata[LVL_W-1:0];
          default: ;
        endcase
      end
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      phase_r     <= phase_nxt;
      level_r     <= level_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nsh_r  <= nsh_nxt;
    drem_r <= drem_nxt;
    quo_r  <= quo_nxt;
    ovf_r  <= ovf_nxt;
    half_r <= half_nxt;
    byp_r  <= byp_nxt;
    mix_r  <= mix_nxt;
    out_r  <= out_nxt;
    for (int i = 0; i < 2; i++) begin
      erem_r[i] <= erem_nxt[i];
      rq_r[i]   <= rq_nxt[i];
      rise_r[i] <= rise_nxt[i];
      fall_r[i] <= fall_nxt[i];
      sq_r[i]   <= sq_nxt[i];
    end
  end

  a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_DIV))
    else $error("accepted beat did not start the phase-step divider");

  a_phase_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQ) |=> (phase_r == PHASE_BITS'($past(phase_r) + $past(quo_r))))
    else $error("phase did not advance by the step");

  a_lane0_rem: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_EDGE) && (rise_r[0] || fall_r[0])) |-> (erem_r[0] < quo_r))
    else $error("edge lane 0 remainder not below the step");

  a_lane1_rem: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_EDGE) && (rise_r[1] || fall_r[1])) |-> (erem_r[1] < quo_r))
    else $error("edge lane 1 remainder not below the step");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_OUT) && (!out_valid_r || !out_stall)) |=>
      (out_valid_r && (state_r == S_IDLE)))
    else $error("finished sample was not loaded into the output register");

endmodule

// File: verif/tb_polyblep_sub_square_oscillator_top.sv
`timescale 1ns / 100ps

module tb_polyblep_sub_square_oscillator_top;
  import pbsso_pkg::*;

  localparam int PHASE_W = PHASE_BITS_DEF;
  localparam int SAMPLE_W = SAMPLE_BITS_DEF;
  localparam int FRAC_W = SAMPLE_W - 1;
  localparam longint CYCLE = longint'(1) << PHASE_W;
  localparam longint UNIT = longint'(1) << FRAC_W;
  localparam longint SAT_LIM = UNIT - 1;
  localparam longint ONE16 = longint'(1) << Q16_SHIFT;
  localparam int STUCK_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = REG_SAMPLE_RATE;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [PITCH_W-1:0] in_pitch_freq = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample_out;

  polyblep_sub_square_oscillator_top #(
    .PHASE_BITS(PHASE_W),
    .SAMPLE_BITS(SAMPLE_W)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_pitch_freq(in_pitch_freq),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_sample_out(out_sample_out)
  );

  // oscillator state and register shadows
  int rate_reg = int'(SR_RESET);
  int oct_reg = int'(OCT_RESET);
  int tgt_reg = 0;
  int smooth_reg = int'(Q16_ONE);
  longint phase_acc = 0;
  int byp_level = 0;

  logic [PITCH_W-1:0] pitch_queue[$];
  logic signed [SAMPLE_W-1:0] expected_samples[$];
  logic signed [SAMPLE_W-1:0] want_sample;
  int pitches_sent = 0;
  int pitches_taken = 0;
  int mismatch_count = 0;
  int in_gap = 0;
  int stall_gap = 0;
  int stuck_cycles = 0;
  bit calm = 1'b0;
  bit in_beat = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint blep_residual(input longint t, input longint dt);
    longint d;
    if (t < dt) begin
      d = UNIT - ((t << FRAC_W) / dt);
      return -((d * d) >>> FRAC_W);
    end
    if (t > CYCLE - dt) begin
      d = UNIT - (((CYCLE - t) << FRAC_W) / dt);
      return (d * d) >>> FRAC_W;
    end
    return 0;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] next_sub_sample(
    input logic [PITCH_W-1:0] pitch
  );
    longint tgt, sm, rate, dt, t, osc, acc;
    int oct;
    tgt = (tgt_reg > ONE16) ? ONE16 : tgt_reg;
    sm = (smooth_reg > ONE16) ? ONE16 : smooth_reg;
    byp_level = byp_level + int'(((tgt - byp_level) * sm + 32768) >>> Q16_SHIFT);
    oct = (oct_reg < 1) ? 1 : ((oct_reg > 2) ? 2 : oct_reg);
    rate = (rate_reg == 0) ? 1 : rate_reg;
    dt = (longint'(pitch) << (PHASE_W - 4 - oct)) / rate;
    if (dt > CYCLE - 1)
      dt = CYCLE - 1;
    t = phase_acc;
    osc = (t < CYCLE / 2) ? UNIT : -UNIT;
    osc = osc + blep_residual(t, dt) - blep_residual((t + CYCLE / 2) % CYCLE, dt);
    phase_acc = (t + dt) % CYCLE;
    acc = (osc * (ONE16 - byp_level) + 32768) >>> Q16_SHIFT;
    if (acc > SAT_LIM)
      acc = SAT_LIM;
    if (acc < -SAT_LIM)
      acc = -SAT_LIM;
    return acc[SAMPLE_W-1:0];
  endfunction

  function automatic logic [PITCH_W-1:0] pick_pitch();
    case ($urandom_range(0, 9))
      0: return '0;
      1, 2: return PITCH_W'($urandom_range(0, (1 << PITCH_W) - 1));
      3: return PITCH_W'($urandom_range(1, 64));
      default: return PITCH_W'($urandom_range(320, 320000));
    endcase
  endfunction

  task automatic queue_pitch(input logic [PITCH_W-1:0] pitch);
    pitch_queue.push_back(pitch);
    pitches_sent++;
  endtask

  task automatic queue_random(input int count);
    repeat (count) queue_pitch(pick_pitch());
  endtask

  // hold until every accepted pitch has produced its sample
  task automatic wait_drained();
    while (pitches_taken != pitches_sent || expected_samples.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= CFG_W'(value);
    case (idx)
      REG_SAMPLE_RATE: rate_reg = value & ((1 << SR_W) - 1);
      REG_OCTAVE: oct_reg = value & ((1 << OCT_W) - 1);
      REG_BYP_TARGET: tgt_reg = value & ((1 << LVL_W) - 1);
      REG_BYP_SMOOTH: smooth_reg = value & ((1 << LVL_W) - 1);
      default: ;
    endcase
  endtask

  task automatic apply_setting(input int rate, input int oct, input int tgt, input int sm);
    wait_drained();
    write_reg(REG_SAMPLE_RATE, rate);
    write_reg(REG_OCTAVE, oct);
    write_reg(REG_BYP_TARGET, tgt);
    write_reg(REG_BYP_SMOOTH, sm);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // pitch driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_beat) begin
        if (in_gap == 0 && !calm && pitch_queue.size() != 0 && $urandom_range(0, 3) == 0)
          in_gap = $urandom_range(1, 17);
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pitch_queue.size() != 0) begin
          in_valid <= 1'b1;
          in_pitch_freq <= pitch_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (stall_gap == 0 && !calm && $urandom_range(0, 5) == 0)
        stall_gap = $urandom_range(1, 17);
      if (stall_gap > 0) begin
        stall_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // predict on each pitch beat, check each sample beat
  always @(posedge clk) begin
    in_beat <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_samples.push_back(next_sub_sample(in_pitch_freq));
        pitches_taken++;
      end
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: sample_out expected none actual %0d", $time, out_sample_out);
          mismatch_count++;
        end else begin
          want_sample = expected_samples.pop_front();
          if (out_sample_out !== want_sample) begin
            $display("%0t: sample_out expected %0d actual %0d", $time, want_sample,
                     out_sample_out);
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin
    while (stuck_cycles < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        stuck_cycles = 0;
      else
        stuck_cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: zero step, field extremes, alternating bits
    queue_pitch('0);
    queue_pitch('0);
    queue_pitch('1);
    queue_pitch('1);
    queue_pitch(PITCH_W'(1));
    queue_pitch(PITCH_W'(19'h55555));
    queue_pitch(PITCH_W'(19'h2AAAA));
    queue_pitch(PITCH_W'(7040));
    queue_pitch(PITCH_W'(7040));
    queue_pitch(PITCH_W'(262144));

    // low rate: steps over half a cycle overlap the edges, top pitch saturates
    apply_setting(8000, 1, 0, int'(Q16_ONE));
    queue_pitch(PITCH_W'(200000));
    queue_pitch(PITCH_W'(200000));
    queue_pitch(PITCH_W'(200000));
    queue_pitch('1);
    queue_pitch('1);
    queue_pitch(PITCH_W'(100000));
    queue_pitch(PITCH_W'(150000));
    queue_pitch('0);

    apply_setting(44100, 1, 0, int'(Q16_ONE));
    queue_random(60);
    apply_setting(8000, 0, int'(Q16_ONE), int'(Q16_ONE));
    queue_random(30);
    apply_setting(192000, 2, 0, 2048);
    queue_random(60);
    // zero rate, octave above range, smoothing above full scale
    apply_setting(0, 3, 20000, (1 << LVL_W) - 1);
    queue_random(30);
    apply_setting(96000, 1, (1 << LVL_W) - 1, 700);
    queue_random(60);
    apply_setting((1 << SR_W) - 1, 2, int'(Q16_ONE), 0);
    queue_random(50);
    repeat (2) begin
      apply_setting($urandom_range(8000, 192000), $urandom_range(0, 3),
                    $urandom_range(0, (1 << LVL_W) - 1), $urandom_range(0, (1 << LVL_W) - 1));
      queue_random(60);
    end

    calm = 1'b1;
    apply_setting(48000, 1, 0, int'(Q16_ONE));
    queue_random(60);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// File: sim.f
hdl/pbsso_pkg.sv
hdl/polyblep_sub_square_oscillator_top.sv
verif/tb_polyblep_sub_square_oscillator_top.sv
